// ===== sv/mhf_pkg.sv =====
package mhf_pkg;

    localparam int MAC_W      = 48;
    localparam int CRC_W      = 32;
    localparam int BUCKET_W   = 6;
    localparam int TABLE_W    = 64;
    localparam int BUCKET_LSB = 23;
    localparam int BIT_CNT_W  = $clog2(MAC_W);

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic JOIN_CMD  = 1'b0;
    localparam logic LEAVE_CMD = 1'b1;

    typedef struct packed {
        logic start;
    } crc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } crc_stat_t;

endpackage

// ===== sv/multicast_hash_filter_top.sv =====
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | s_valid s_ready s_command s_mac_address      | in
// result   | m_valid m_ready m_bucket m_was_set           | out
//          | m_filter_table                               |
//
// Each item is accepted, passed through the bit-serial CRC unit (one address
// bit per cycle), and then used to update the table and register the result.
// s_ready is high only while the sequencer is idle, so a new item is not
// accepted until the result of the previous one has been registered.
// Reset (aresetn low, synchronous) clears the hash table and all control.
// A result that is not taken holds the output register; the finished item
// then waits with s_ready low for as long as the old result stays.
module multicast_hash_filter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [mhf_pkg::MAC_W-1:0]     s_mac_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mhf_pkg::BUCKET_W-1:0]  m_bucket,
    output logic                          m_was_set,
    output logic [mhf_pkg::TABLE_W-1:0]   m_filter_table
);
    import mhf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                cmd_reg;
    logic [TABLE_W-1:0]  table_reg, table_next;
    logic                m_valid_reg, m_valid_next;
    logic [BUCKET_W-1:0] bucket_reg;
    logic                was_set_reg;

    crc_ctrl_t          crc_ctrl;
    crc_stat_t          crc_stat;
    logic [CRC_W-1:0]   crc;
    logic [BUCKET_W-1:0] bucket;
    logic [TABLE_W-1:0] bit_mask;
    logic               accept;
    logic               out_free;
    logic               load;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign crc_ctrl.start = accept;

    mhf_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .mac     (s_mac_address),
        .stat    (crc_stat),
        .crc     (crc)
    );

    // crc holds its final value until the next start, so WAIT may reuse it
    assign bucket   = crc[BUCKET_LSB +: BUCKET_W];
    assign bit_mask = TABLE_W'(1) << bucket;
    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free &&
                      (((state_reg == ST_CRC) && crc_stat.done) || (state_reg == ST_WAIT));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_CRC;
            end
            ST_CRC: begin
                if (crc_stat.done) state_next = out_free ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        table_next = table_reg;
        if (load) begin
            table_next = (cmd_reg == LEAVE_CMD) ? (table_reg & ~bit_mask)
                                                : (table_reg | bit_mask);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (load)                   m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (accept) cmd_reg <= s_command;
        if (load) begin
            bucket_reg  <= bucket;
            was_set_reg <= |(table_reg & bit_mask);
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            table_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            table_reg   <= table_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket       = bucket_reg;
    assign m_was_set      = was_set_reg;
    assign m_filter_table = table_reg;

    // idle sequencer never overlaps a running CRC
    a_idle_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !crc_stat.busy)
        else $error("CRC unit busy while idle");

    // CRC completion is only seen while the sequencer waits for it
    a_done_in_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        crc_stat.done |-> (state_reg == ST_CRC))
        else $error("CRC done outside CRC state");

    // table moves only when a result is registered
    a_table_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(table_reg))
        else $error("hash table changed without a result");

    // updated bucket bit matches the command of the item just finished
    a_bit_follows_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (table_reg[bucket_reg] == ($past(cmd_reg) == JOIN_CMD)))
        else $error("bucket bit does not follow command");

endmodule

// ===== sv/mhf_crc_serial.sv =====
module mhf_crc_serial (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mhf_pkg::crc_ctrl_t        ctrl,
    input  logic [mhf_pkg::MAC_W-1:0] mac,
    output mhf_pkg::crc_stat_t        stat,
    output logic [mhf_pkg::CRC_W-1:0] crc
);
    import mhf_pkg::*;

    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [MAC_W-1:0]     data_reg, data_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MAC_W-1:0]     mac_swapped;
    logic                 fb;

    // byte 0 moved to the bottom so bits leave in wire order from bit 0
    always_comb begin
        for (int b = 0; b < MAC_W / 8; b++) begin
            mac_swapped[8*b +: 8] = mac[MAC_W - 8 - 8*b +: 8];
        end
    end

    assign fb = data_reg[0] ^ crc_reg[0];

    always_comb begin
        crc_next  = crc_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            crc_next  = CRC_INIT;
            data_next = mac_swapped;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next  = (crc_reg >> 1) ^ (fb ? CRC_POLY : '0);
            data_next = data_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(MAC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign crc       = crc_reg;

endmodule

// ===== tb/sv/tb_multicast_hash_filter_top.sv =====
`timescale 1ns / 1ps

module tb_multicast_hash_filter_top;
    import mhf_pkg::*;

    // Run shape
    localparam int CLK_HALF     = 6;        // 12 ns period
    localparam int RESET_CYCLES = 6;
    localparam int ITEMS_PER_PH = 238;      // four idling phases, ~950 random items
    localparam int POOL_N       = 24;       // group addresses reused so leaves hit set bits
    localparam int DRAIN_CYCLES = 120;      // idle wait after the last result, to catch stray items
    localparam int CYCLE_LIMIT  = 1000000;  // expected run is well under this
    localparam int PRINT_CAP    = 20;       // mismatch lines printed before going quiet

    // One expected result item
    typedef struct {
        logic [BUCKET_W-1:0] bucket;
        logic                was_set;
        logic [TABLE_W-1:0]  filter_bits;
    } filter_result_t;

    // Tracks the hash table as the block should hold it and checks each result
    // item against the oldest pending update.
    class filter_table_tracker;
        logic [TABLE_W-1:0] model_bits;
        filter_result_t     pending_updates[$];
        int                 mismatches;
        int                 results_seen;
        int                 repeat_joins;
        int                 absent_leaves;

        function new();
            model_bits    = '0;
            mismatches    = 0;
            results_seen  = 0;
            repeat_joins  = 0;
            absent_leaves = 0;
        endfunction

        // Reflected CRC-32, byte 0 (bits 47..40) first, LSB first, no final invert
        function logic [CRC_W-1:0] mac_crc(logic [MAC_W-1:0] mac);
            logic [CRC_W-1:0] crc;
            logic [7:0]       octet;
            logic             fb;
            crc = CRC_INIT;
            for (int b = 0; b < MAC_W / 8; b++) begin
                octet = mac[MAC_W-1-8*b -: 8];
                for (int k = 0; k < 8; k++) begin
                    fb    = octet[0] ^ crc[0];
                    crc   = crc >> 1;
                    octet = octet >> 1;
                    if (fb) begin
                        crc = crc ^ CRC_POLY;
                    end
                end
            end
            return crc;
        endfunction

        function logic [BUCKET_W-1:0] hash_bucket(logic [MAC_W-1:0] mac);
            logic [CRC_W-1:0] crc;
            crc = mac_crc(mac);
            return crc[BUCKET_LSB +: BUCKET_W];
        endfunction

        function void note_input(logic cmd, logic [MAC_W-1:0] mac);
            filter_result_t     upd;
            logic [TABLE_W-1:0] mask;
            upd.bucket  = hash_bucket(mac);
            mask        = '0;
            mask[upd.bucket] = 1'b1;
            upd.was_set = |(model_bits & mask);
            if (cmd == LEAVE_CMD) begin
                model_bits = model_bits & ~mask;
                if (!upd.was_set) absent_leaves++;
            end else begin
                model_bits = model_bits | mask;
                if (upd.was_set) repeat_joins++;
            end
            upd.filter_bits = model_bits;
            pending_updates.push_back(upd);
        endfunction

        function int pending();
            return pending_updates.size();
        endfunction

        task report_mismatch(string what, logic [TABLE_W-1:0] got, logic [TABLE_W-1:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
            end
        endtask

        task check_result(logic [BUCKET_W-1:0] bucket, logic was_set,
                          logic [TABLE_W-1:0] filter_bits);
            filter_result_t want;
            results_seen++;
            if (pending_updates.size() == 0) begin
                report_mismatch("result item with nothing pending", filter_bits, '0);
            end else begin
                want = pending_updates.pop_front();
                if (bucket !== want.bucket) begin
                    report_mismatch("bucket", TABLE_W'(bucket), TABLE_W'(want.bucket));
                end
                if (was_set !== want.was_set) begin
                    report_mismatch("was_set", TABLE_W'(was_set), TABLE_W'(want.was_set));
                end
                if (filter_bits !== want.filter_bits) begin
                    report_mismatch("filter_table", filter_bits, want.filter_bits);
                end
            end
        endtask
    endclass

    // DUT ports; every input known from time zero
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_command     = JOIN_CMD;
    logic [MAC_W-1:0]     s_mac_address = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [BUCKET_W-1:0]  m_bucket;
    logic                 m_was_set;
    logic [TABLE_W-1:0]   m_filter_table;

    filter_table_tracker tracker = new();

    // Idling knobs, changed between phases by the stimulus process
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;
    int directed_items = 0;

    logic [MAC_W-1:0] group_pool [POOL_N];

    multicast_hash_filter_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_mac_address  (s_mac_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket       (m_bucket),
        .m_was_set      (m_was_set),
        .m_filter_table (m_filter_table)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, tracker.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check on a handshake seen at this edge, then pick the next
    // ready level. Exactly one NBA to m_ready per edge.
    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            tracker.check_result(m_bucket, m_was_set, m_filter_table);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    // Offers one item, holding it until taken. Valid is only lowered when an
    // idle gap is actually wanted, so no step sees it dropped and raised.
    task automatic send_item(input logic cmd, input logic [MAC_W-1:0] mac);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_mac_address <= mac;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_input(cmd, mac);
    endtask

    // Mostly joins and leaves on a small pool of groups, so buckets fill and
    // empty; a share of fresh addresses acts as noise and refreshes the pool.
    task automatic run_random(input int count);
        logic [MAC_W-1:0] mac;
        logic             cmd;
        int               slot;
        for (int i = 0; i < count; i++) begin
            slot = $urandom_range(POOL_N - 1);
            if ($urandom_range(99) < 15) begin
                mac = random_mac();
                if ($urandom_range(1) == 1) group_pool[slot] = mac;
            end else begin
                mac = group_pool[slot];
            end
            cmd = ($urandom_range(99) < 55) ? JOIN_CMD : LEAVE_CMD;
            send_item(cmd, mac);
        end
    endtask

    initial begin
        logic [MAC_W-1:0] grp_a;
        logic [MAC_W-1:0] grp_twin;

        // Half the pool looks like real multicast groups (group bit set)
        for (int p = 0; p < POOL_N; p++) begin
            group_pool[p] = random_mac();
            if (p % 2 == 0) group_pool[p][40] = 1'b1;
        end

        // Find a second address landing in the same bucket as grp_a
        grp_a    = 48'h01_00_5E_00_00_01;
        grp_twin = grp_a;
        for (int k = 1; k < 4096; k++) begin
            if (tracker.hash_bucket(grp_a ^ MAC_W'(k)) == tracker.hash_bucket(grp_a)) begin
                grp_twin = grp_a ^ MAC_W'(k);
                break;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling: field extremes, repeated join, leave of an
        // absent group, and two addresses sharing one bucket.
        send_item(JOIN_CMD,  48'h0000_0000_0000);
        send_item(JOIN_CMD,  48'hFFFF_FFFF_FFFF);
        send_item(JOIN_CMD,  48'h0000_0000_0000);   // repeated join
        send_item(LEAVE_CMD, 48'h0123_4567_89AB);   // most likely absent
        send_item(JOIN_CMD,  grp_a);
        send_item(JOIN_CMD,  grp_twin);             // bucket already set
        send_item(LEAVE_CMD, grp_a);                // clears the shared bit
        send_item(LEAVE_CMD, grp_twin);             // now absent
        send_item(LEAVE_CMD, 48'hFFFF_FFFF_FFFF);
        send_item(LEAVE_CMD, 48'h0000_0000_0000);
        send_item(LEAVE_CMD, 48'h0000_0000_0000);   // leave on an empty table
        send_item(JOIN_CMD,  48'hAAAA_AAAA_AAAA);
        send_item(JOIN_CMD,  48'h5555_5555_5555);
        send_item(JOIN_CMD,  48'h8000_0000_0000);
        send_item(JOIN_CMD,  48'h0000_0000_0001);
        send_item(JOIN_CMD,  48'h3333_0000_0001);
        send_item(LEAVE_CMD, 48'hAAAA_AAAA_AAAA);
        send_item(LEAVE_CMD, 48'h5555_5555_5555);
        send_item(LEAVE_CMD, 48'h3333_0000_0001);
        directed_items = 19;

        // Random part across the idling phases
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random(ITEMS_PER_PH);
        src_idle_pct = 83; sink_stall_pct = 0;
        run_random(ITEMS_PER_PH);
        src_idle_pct = 0;  sink_stall_pct = 83;
        run_random(ITEMS_PER_PH);
        src_idle_pct = 34; sink_stall_pct = 34;
        run_random(ITEMS_PER_PH);
        s_valid <= 1'b0;

        // Let the last result items out, then watch for strays
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items (%0d directed), %0d result items checked, %0d mismatches",
                 directed_items + 4 * ITEMS_PER_PH, directed_items,
                 tracker.results_seen, tracker.mismatches);
        $display("repeated joins %0d, leaves of absent groups %0d, final table %016h",
                 tracker.repeat_joins, tracker.absent_leaves, tracker.model_bits);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mhf_pkg.sv
sv/mhf_crc_serial.sv
sv/multicast_hash_filter_top.sv
tb/sv/tb_multicast_hash_filter_top.sv
